// File: hw/rtl/fsef_pkg.sv
`default_nettype none
package fsef_pkg;

   localparam int NUM_SITES      = 4096;
   localparam int MAX_CELLS      = 8;
   localparam int SPIN_FRAC_BITS = 14;
   localparam int COUPLING_FRAC  = 8;

   localparam int SITE_W  = $clog2(NUM_SITES);
   localparam int SLOT_W  = $clog2(MAX_CELLS);
   localparam int CNT_W   = $clog2(MAX_CELLS + 1);
   localparam int IDX_W   = 12;
   localparam int SPIN_W  = 16;
   localparam int CFG_W   = 16;
   localparam int CPS_W   = 4;
   localparam int DOT_W   = 19;
   localparam int MUL_W   = 20;
   localparam int ACC_W   = 32;
   localparam int RES_W   = 32;
   localparam int NUM_DOTS = 6;
   localparam int NUM_ACC  = 4;

   localparam logic [1:0] OP_SPIN  = 2'd0;
   localparam logic [1:0] OP_CELL  = 2'd1;
   localparam logic [1:0] OP_QUERY = 2'd2;

   localparam logic [1:0] CSR_COUPLING = 2'd0;
   localparam logic [1:0] CSR_CELLS    = 2'd1;

   // spin roles inside a cell
   localparam logic [1:0] R_I = 2'd0;
   localparam logic [1:0] R_J = 2'd1;
   localparam logic [1:0] R_K = 2'd2;
   localparam logic [1:0] R_L = 2'd3;

   localparam logic [2:0] D_IJ = 3'd0;
   localparam logic [2:0] D_KL = 3'd1;
   localparam logic [2:0] D_IL = 3'd2;
   localparam logic [2:0] D_JK = 3'd3;
   localparam logic [2:0] D_IK = 3'd4;
   localparam logic [2:0] D_JL = 3'd5;

   localparam logic [1:0] A_ENERGY = 2'd0;
   localparam logic [1:0] A_FX     = 2'd1;
   localparam logic [1:0] A_FY     = 2'd2;
   localparam logic [1:0] A_FZ     = 2'd3;

   typedef struct packed {
      logic [SPIN_W-1:0] z;
      logic [SPIN_W-1:0] y;
      logic [SPIN_W-1:0] x;
   } spin_type;

   typedef struct packed {
      logic             present;
      logic [IDX_W-1:0] d;
      logic [IDX_W-1:0] c;
      logic [IDX_W-1:0] b;
      logic [IDX_W-1:0] a;
   } cell_type;

   typedef struct packed {
      logic       clr;
      logic       spin_ld;
      logic [1:0] spin_sel;
      logic       dot_en;
      logic [2:0] dot_sel;
      logic       acc_en;
      logic [1:0] acc_sel;
      logic       fin_en;
      logic [1:0] fin_sel;
   } calc_ctrl_type;

   function automatic logic [1:0] dot_left(input logic [2:0] sel);
      logic [1:0] r;
      unique case (sel)
         D_IJ:    r = R_I;
         D_KL:    r = R_K;
         D_IL:    r = R_I;
         D_JK:    r = R_J;
         D_IK:    r = R_I;
         default: r = R_J;
      endcase
      return r;
   endfunction

   function automatic logic [1:0] dot_right(input logic [2:0] sel);
      logic [1:0] r;
      unique case (sel)
         D_IJ:    r = R_J;
         D_KL:    r = R_L;
         D_IL:    r = R_L;
         D_JK:    r = R_K;
         D_IK:    r = R_K;
         default: r = R_L;
      endcase
      return r;
   endfunction

   function automatic logic [IDX_W-1:0] cell_idx(input cell_type c, input logic [1:0] role);
      logic [IDX_W-1:0] r;
      unique case (role)
         R_I:     r = c.a;
         R_J:     r = c.b;
         R_K:     r = c.c;
         default: r = c.d;
      endcase
      return r;
   endfunction

   // field component q (1..3 maps to x,y,z) of a spin, widened for the multiplier
   function automatic logic signed [MUL_W-1:0] spin_comp(input spin_type s,
                                                         input logic [1:0] q);
      logic [SPIN_W-1:0] v;
      unique case (q)
         A_FX:    v = s.x;
         A_FY:    v = s.y;
         default: v = s.z;
      endcase
      return {{(MUL_W-SPIN_W){v[SPIN_W-1]}}, v};
   endfunction

   function automatic logic signed [MUL_W-1:0] ext_dot(input logic signed [DOT_W-1:0] v);
      return {{(MUL_W-DOT_W){v[DOT_W-1]}}, v};
   endfunction

endpackage
`default_nettype wire

// File: hw/rtl/fsef_spin_mem.sv
`default_nettype none
module fsef_spin_mem (
   input  wire logic                          clock,
   input  wire logic                          we,
   input  wire logic [fsef_pkg::SITE_W-1:0]   addr,
   input  wire fsef_pkg::spin_type            wdata,
   output fsef_pkg::spin_type                 rdata
);

   fsef_pkg::spin_type mem [fsef_pkg::NUM_SITES];
   fsef_pkg::spin_type rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

// File: hw/rtl/fsef_cell_mem.sv
`default_nettype none
module fsef_cell_mem (
   input  wire logic                            clock,
   input  wire logic                            we,
   input  wire logic [fsef_pkg::MAX_CELLS-1:0]  wmask,
   input  wire logic                            re,
   input  wire logic [fsef_pkg::SITE_W-1:0]     addr,
   input  wire fsef_pkg::cell_type              wdata,
   output fsef_pkg::cell_type                   rdata [fsef_pkg::MAX_CELLS]
);

   // one row per site, slots written selectively
   fsef_pkg::cell_type mem [fsef_pkg::NUM_SITES][fsef_pkg::MAX_CELLS];
   fsef_pkg::cell_type rdata_ff [fsef_pkg::MAX_CELLS];

   always_ff @(posedge clock) begin
      if (we) begin
         for (int s = 0; s < fsef_pkg::MAX_CELLS; s++) begin
            if (wmask[s]) begin
               mem[addr][s] <= wdata;
            end
         end
      end
      if (re) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

// File: hw/rtl/fsef_calc.sv
`default_nettype none
module fsef_calc (
   input  wire logic                                clock,
   input  wire fsef_pkg::calc_ctrl_type             ctrl,
   input  wire fsef_pkg::spin_type                  spin_rdata,
   input  wire logic signed [fsef_pkg::CFG_W-1:0]   coupling,
   output logic [fsef_pkg::RES_W-1:0]               site_energy,
   output logic [fsef_pkg::RES_W-1:0]               field_x,
   output logic [fsef_pkg::RES_W-1:0]               field_y,
   output logic [fsef_pkg::RES_W-1:0]               field_z
);

   localparam int DSUM_W = 2 * fsef_pkg::SPIN_W + 2;
   localparam int PROD_W = 2 * fsef_pkg::MUL_W;
   localparam int FP_W   = fsef_pkg::CFG_W + fsef_pkg::ACC_W;
   localparam logic signed [FP_W:0] SAT_MAX = (FP_W+1)'(64'sh7FFF_FFFF);
   localparam logic signed [FP_W:0] SAT_MIN = -(FP_W+1)'(64'sh8000_0000);

   fsef_pkg::spin_type                     sp_ff  [4];
   logic signed [fsef_pkg::DOT_W-1:0]      dot_ff [fsef_pkg::NUM_DOTS];
   logic signed [fsef_pkg::ACC_W-1:0]      acc_ff [fsef_pkg::NUM_ACC];
   logic signed [fsef_pkg::RES_W-1:0]      res_ff [fsef_pkg::NUM_ACC];

   fsef_pkg::spin_type                     sa, sb;
   logic signed [DSUM_W-1:0]               dsum;
   logic signed [fsef_pkg::DOT_W-1:0]      dot_new;
   logic signed [fsef_pkg::MUL_W-1:0]      jl_w, jl_neg;
   logic signed [fsef_pkg::MUL_W-1:0]      m0a, m0b, m1a, m1b, m2a, m2b;
   logic signed [PROD_W-1:0]               p0, p1, p2, s0, s1, s2;
   logic signed [fsef_pkg::ACC_W-1:0]      tsum;
   logic signed [FP_W-1:0]                 fprod, fsh;
   logic signed [FP_W:0]                   fext, fval;
   logic signed [fsef_pkg::RES_W-1:0]      fsat;

   always_comb begin
      sa   = sp_ff[fsef_pkg::dot_left(ctrl.dot_sel)];
      sb   = sp_ff[fsef_pkg::dot_right(ctrl.dot_sel)];
      dsum = $signed(sa.x) * $signed(sb.x) + $signed(sa.y) * $signed(sb.y)
           + $signed(sa.z) * $signed(sb.z);
      // arithmetic shift then keep the low bits of the dot product
      dot_new = dsum[fsef_pkg::SPIN_FRAC_BITS +: fsef_pkg::DOT_W];
   end

   always_comb begin
      jl_w   = fsef_pkg::ext_dot(dot_ff[fsef_pkg::D_JL]);
      jl_neg = -jl_w;
      unique case (ctrl.acc_sel)
         fsef_pkg::A_ENERGY: begin
            m0a = fsef_pkg::ext_dot(dot_ff[fsef_pkg::D_IJ]);
            m0b = fsef_pkg::ext_dot(dot_ff[fsef_pkg::D_KL]);
            m1a = fsef_pkg::ext_dot(dot_ff[fsef_pkg::D_IL]);
            m1b = fsef_pkg::ext_dot(dot_ff[fsef_pkg::D_JK]);
            m2a = fsef_pkg::ext_dot(dot_ff[fsef_pkg::D_IK]);
            m2b = jl_w;
         end
         default: begin
            m0a = fsef_pkg::spin_comp(sp_ff[fsef_pkg::R_J], ctrl.acc_sel);
            m0b = fsef_pkg::ext_dot(dot_ff[fsef_pkg::D_KL]);
            m1a = fsef_pkg::spin_comp(sp_ff[fsef_pkg::R_L], ctrl.acc_sel);
            m1b = fsef_pkg::ext_dot(dot_ff[fsef_pkg::D_JK]);
            m2a = fsef_pkg::spin_comp(sp_ff[fsef_pkg::R_K], ctrl.acc_sel);
            m2b = jl_neg;
         end
      endcase
      p0 = m0a * m0b;
      p1 = m1a * m1b;
      p2 = m2a * m2b;
      s0 = p0 >>> fsef_pkg::SPIN_FRAC_BITS;
      s1 = p1 >>> fsef_pkg::SPIN_FRAC_BITS;
      s2 = p2 >>> fsef_pkg::SPIN_FRAC_BITS;
      // energy subtracts the third term, the field already carries -jl
      if (ctrl.acc_sel == fsef_pkg::A_ENERGY) begin
         tsum = s0[fsef_pkg::ACC_W-1:0] + s1[fsef_pkg::ACC_W-1:0]
              - s2[fsef_pkg::ACC_W-1:0];
      end else begin
         tsum = s0[fsef_pkg::ACC_W-1:0] + s1[fsef_pkg::ACC_W-1:0]
              + s2[fsef_pkg::ACC_W-1:0];
      end
   end

   always_comb begin
      fprod = coupling * acc_ff[ctrl.fin_sel];
      fsh   = fprod >>> fsef_pkg::COUPLING_FRAC;
      fext  = {fsh[FP_W-1], fsh};
      fval  = (ctrl.fin_sel == fsef_pkg::A_ENERGY) ? -fext : fext;
      if (fval > SAT_MAX) begin
         fsat = SAT_MAX[fsef_pkg::RES_W-1:0];
      end else if (fval < SAT_MIN) begin
         fsat = SAT_MIN[fsef_pkg::RES_W-1:0];
      end else begin
         fsat = fval[fsef_pkg::RES_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.spin_ld) begin
         sp_ff[ctrl.spin_sel] <= spin_rdata;
      end
      if (ctrl.dot_en) begin
         dot_ff[ctrl.dot_sel] <= dot_new;
      end
      if (ctrl.clr) begin
         for (int a = 0; a < fsef_pkg::NUM_ACC; a++) begin
            acc_ff[a] <= '0;
         end
      end else if (ctrl.acc_en) begin
         acc_ff[ctrl.acc_sel] <= acc_ff[ctrl.acc_sel] + tsum;
      end
      if (ctrl.fin_en) begin
         res_ff[ctrl.fin_sel] <= fsat;
      end
   end

   assign site_energy = res_ff[fsef_pkg::A_ENERGY];
   assign field_x     = res_ff[fsef_pkg::A_FX];
   assign field_y     = res_ff[fsef_pkg::A_FY];
   assign field_z     = res_ff[fsef_pkg::A_FZ];

endmodule
`default_nettype wire

// File: hw/rtl/four_spin_energy_and_field.sv
// four-spin exchange energy and effective field of one lattice site
// writes of a spin or a cell slot are stored in the cycle they are accepted
// a query walks the site's slots: each present cell takes four spin reads on
// the single spin memory port, six dot products and four accumulate steps;
// an absent slot is stepped over; final scaling waits until results are taken
// after reset a clearing pass over all NUM_SITES rows empties the cell table
`default_nettype none
module four_spin_energy_and_field (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   // site_index, cell_slot, spin_x, spin_y, spin_z, cell_present,
   // spin_a, spin_b, spin_c, spin_d
   input  wire logic [111:0]  req_tdata,
   // opcode
   input  wire logic [1:0]    req_tuser,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   // site_energy, field_x, field_y, field_z
   output logic [127:0]       rsp_tdata,
   input  wire logic          csr_valid,
   output logic               csr_ready,
   input  wire logic [1:0]    csr_index,
   input  wire logic [15:0]   csr_data
);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_SLOT  = 3'd2;
   localparam logic [2:0] S_READ  = 3'd3;
   localparam logic [2:0] S_DOT   = 3'd4;
   localparam logic [2:0] S_ACC   = 3'd5;
   localparam logic [2:0] S_FIN   = 3'd6;

   localparam int SW = fsef_pkg::SITE_W;
   localparam int CW = fsef_pkg::CNT_W;

   logic [2:0]                       state_ff, state_in;
   logic [SW-1:0]                    clr_ff, clr_in;
   logic                             site_ok_ff, site_ok_in;
   logic [CW-1:0]                    slot_ff, slot_in;
   logic [2:0]                       ph_ff, ph_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic signed [fsef_pkg::CFG_W-1:0] coupling_ff;
   logic [fsef_pkg::CPS_W-1:0]       cps_ff;

   logic [1:0]                       req_op;
   logic [SW-1:0]                    req_site;
   logic [2:0]                       req_slot;
   fsef_pkg::spin_type               req_spin;
   fsef_pkg::cell_type               req_cell;
   logic                             req_site_ok, req_slot_ok, req_acc;

   logic                             spin_we;
   logic [SW-1:0]                    spin_addr;
   fsef_pkg::spin_type               spin_rdata;
   logic                             cell_we, cell_re;
   logic [fsef_pkg::MAX_CELLS-1:0]   cell_wmask;
   logic [SW-1:0]                    cell_addr;
   fsef_pkg::cell_type               cell_wdata;
   fsef_pkg::cell_type               cell_rdata [fsef_pkg::MAX_CELLS];
   fsef_pkg::cell_type               cur_cell;
   logic [CW-1:0]                    n_cells;
   fsef_pkg::calc_ctrl_type          ctrl;
   logic [fsef_pkg::RES_W-1:0]       res_e, res_x, res_y, res_z;

   assign req_op      = req_tuser;
   assign req_site    = req_tdata[11:0];
   assign req_slot    = req_tdata[14:12];
   assign req_spin    = '{z: req_tdata[62:47], y: req_tdata[46:31], x: req_tdata[30:15]};
   assign req_cell    = '{present: req_tdata[63], d: req_tdata[111:100],
                          c: req_tdata[99:88], b: req_tdata[87:76], a: req_tdata[75:64]};
   assign req_site_ok = {1'b0, req_tdata[11:0]} < 13'(fsef_pkg::NUM_SITES);
   assign req_slot_ok = {1'b0, req_slot} < 4'(fsef_pkg::MAX_CELLS);

   assign req_tready = (state_ff == S_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign cur_cell = cell_rdata[slot_ff[fsef_pkg::SLOT_W-1:0]];
   assign n_cells  = !site_ok_ff ? '0 :
                     (cps_ff > fsef_pkg::CPS_W'(fsef_pkg::MAX_CELLS)) ?
                     CW'(fsef_pkg::MAX_CELLS) : CW'(cps_ff);

   // memory port control
   always_comb begin
      spin_we    = req_acc && (req_op == fsef_pkg::OP_SPIN) && req_site_ok;
      cell_we    = 1'b0;
      cell_re    = req_acc && (req_op == fsef_pkg::OP_QUERY);
      cell_wdata = req_cell;
      cell_addr  = req_site;
      for (int s = 0; s < fsef_pkg::MAX_CELLS; s++) begin
         cell_wmask[s] = (fsef_pkg::SLOT_W'(s) == req_slot[fsef_pkg::SLOT_W-1:0]);
      end
      if (state_ff == S_CLEAR) begin
         cell_we    = 1'b1;
         cell_wdata = '0;
         cell_addr  = clr_ff;
         cell_wmask = '1;
      end else begin
         cell_we = req_acc && (req_op == fsef_pkg::OP_CELL) && req_site_ok && req_slot_ok;
      end
      unique case (state_ff)
         S_SLOT:  spin_addr = SW'(fsef_pkg::cell_idx(cur_cell, fsef_pkg::R_I));
         S_READ:  spin_addr = SW'(fsef_pkg::cell_idx(cur_cell, ph_ff[1:0]));
         default: spin_addr = req_site;
      endcase
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      site_ok_in   = site_ok_ff;
      slot_in      = slot_ff;
      ph_in        = ph_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      ctrl         = '0;
      unique case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + SW'(1);
            if (clr_ff == SW'(fsef_pkg::NUM_SITES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_acc && (req_op == fsef_pkg::OP_QUERY)) begin
               ctrl.clr   = 1'b1;
               site_ok_in = req_site_ok;
               slot_in    = '0;
               state_in   = S_SLOT;
            end
         end
         S_SLOT: begin
            if (slot_ff >= n_cells) begin
               // result register must be free before the final scaling
               if (!rsp_valid_ff) begin
                  ph_in    = '0;
                  state_in = S_FIN;
               end
            end else if (!cur_cell.present) begin
               slot_in = slot_ff + CW'(1);
            end else begin
               ph_in    = 3'd1;
               state_in = S_READ;
            end
         end
         S_READ: begin
            ctrl.spin_ld  = 1'b1;
            ctrl.spin_sel = 2'(ph_ff - 3'd1);
            ph_in         = ph_ff + 3'd1;
            if (ph_ff == 3'd4) begin
               ph_in    = '0;
               state_in = S_DOT;
            end
         end
         S_DOT: begin
            ctrl.dot_en  = 1'b1;
            ctrl.dot_sel = ph_ff;
            ph_in        = ph_ff + 3'd1;
            if (ph_ff == 3'(fsef_pkg::NUM_DOTS - 1)) begin
               ph_in    = '0;
               state_in = S_ACC;
            end
         end
         S_ACC: begin
            ctrl.acc_en  = 1'b1;
            ctrl.acc_sel = ph_ff[1:0];
            ph_in        = ph_ff + 3'd1;
            if (ph_ff == 3'(fsef_pkg::NUM_ACC - 1)) begin
               ph_in    = '0;
               slot_in  = slot_ff + CW'(1);
               state_in = S_SLOT;
            end
         end
         S_FIN: begin
            ctrl.fin_en  = 1'b1;
            ctrl.fin_sel = ph_ff[1:0];
            ph_in        = ph_ff + 3'd1;
            if (ph_ff == 3'(fsef_pkg::NUM_ACC - 1)) begin
               ph_in        = '0;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         site_ok_ff   <= 1'b0;
         slot_ff      <= '0;
         ph_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         coupling_ff  <= 16'sd256;
         cps_ff       <= 4'd1;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         site_ok_ff   <= site_ok_in;
         slot_ff      <= slot_in;
         ph_ff        <= ph_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               fsef_pkg::CSR_COUPLING: coupling_ff <= csr_data;
               fsef_pkg::CSR_CELLS:    cps_ff      <= csr_data[fsef_pkg::CPS_W-1:0];
               default: ;
            endcase
         end
      end
   end

   fsef_spin_mem u_spin_mem (
      .clock (clock),
      .we    (spin_we),
      .addr  (spin_addr),
      .wdata (req_spin),
      .rdata (spin_rdata)
   );

   fsef_cell_mem u_cell_mem (
      .clock (clock),
      .we    (cell_we),
      .wmask (cell_wmask),
      .re    (cell_re),
      .addr  (cell_addr),
      .wdata (cell_wdata),
      .rdata (cell_rdata)
   );

   fsef_calc u_calc (
      .clock       (clock),
      .ctrl        (ctrl),
      .spin_rdata  (spin_rdata),
      .coupling    (coupling_ff),
      .site_energy (res_e),
      .field_x     (res_x),
      .field_y     (res_y),
      .field_z     (res_z)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {res_z, res_y, res_x, res_e};

   a_fin_free : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN) |-> !rsp_valid_ff)
      else $error("final scaling while a result is still pending");

   a_rsp_from_fin : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_FIN) && ($past(ph_ff) == 3'd3))
      else $error("result raised outside the last scaling step");

   a_slot_range : assert property (@(posedge clock) disable iff (reset)
      slot_ff <= CW'(fsef_pkg::MAX_CELLS))
      else $error("slot counter past the row");

endmodule
`default_nettype wire

// File: verif/tb.sv
module tb;

   typedef struct packed {
      logic signed [31:0] energy;
      logic signed [31:0] fx;
      logic signed [31:0] fy;
      logic signed [31:0] fz;
   } site_result_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [111:0]  req_tdata = '0;
   logic [1:0]    req_tuser = '0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [127:0]  rsp_tdata;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   logic [1:0]    csr_index = '0;
   logic [15:0]   csr_data = '0;

   localparam logic [1:0] OP_NONE = 2'd3;
   localparam logic [1:0] CSR_UNUSED = 2'd2;
   localparam int HOLD_CYCLES = 600;

   four_spin_energy_and_field DUT (.*);

   always #6 clock = ~clock;

   // model state
   logic signed [15:0] mdl_spin [fsef_pkg::NUM_SITES][3];
   bit                 mdl_present [fsef_pkg::NUM_SITES*fsef_pkg::MAX_CELLS];
   logic [11:0]        mdl_idx [fsef_pkg::NUM_SITES*fsef_pkg::MAX_CELLS][4];
   longint             mdl_coupling = 256;
   int unsigned        mdl_cells = 1;
   bit                 spin_written [fsef_pkg::NUM_SITES];
   int                 written_sites [$];
   int                 loaded_sites [$];

   site_result_type field_q [$];
   int  errors = 0;
   int  send_idle_pct = 17;
   int  recv_idle_pct = 17;
   event hold_go;
   logic hold_on = 1'b0;

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   function automatic logic [31:0] sat32(longint v);
      if (v > 64'sd2147483647) return 32'h7fffffff;
      if (v < -64'sd2147483648) return 32'h80000000;
      return v[31:0];
   endfunction

   function automatic longint dot_q(int a, int b);
      longint s;
      s = 0;
      for (int q = 0; q < 3; q++)
         s += longint'(mdl_spin[a][q]) * longint'(mdl_spin[b][q]);
      return s >>> fsef_pkg::SPIN_FRAC_BITS;
   endfunction

   function automatic site_result_type predict_site(int site);
      site_result_type r;
      longint esum, ij, kl, il, jk, ik, jl;
      longint f [3];
      int n, e, si, sj, sk, sl;
      esum = 0;
      f = '{0, 0, 0};
      n = (mdl_cells > fsef_pkg::MAX_CELLS) ? fsef_pkg::MAX_CELLS : int'(mdl_cells);
      for (int c = 0; c < n; c++) begin
         e = site*fsef_pkg::MAX_CELLS + c;
         if (mdl_present[e]) begin
            si = int'(mdl_idx[e][0]); sj = int'(mdl_idx[e][1]);
            sk = int'(mdl_idx[e][2]); sl = int'(mdl_idx[e][3]);
            ij = dot_q(si, sj); kl = dot_q(sk, sl);
            il = dot_q(si, sl); jk = dot_q(sj, sk);
            ik = dot_q(si, sk); jl = dot_q(sj, sl);
            esum += ((ij*kl) >>> fsef_pkg::SPIN_FRAC_BITS)
                    + ((il*jk) >>> fsef_pkg::SPIN_FRAC_BITS)
                    - ((ik*jl) >>> fsef_pkg::SPIN_FRAC_BITS);
            for (int q = 0; q < 3; q++)
               f[q] += ((longint'(mdl_spin[sj][q]) * kl) >>> fsef_pkg::SPIN_FRAC_BITS)
                     + ((longint'(mdl_spin[sl][q]) * jk) >>> fsef_pkg::SPIN_FRAC_BITS)
                     + ((longint'(mdl_spin[sk][q]) * (-jl)) >>> fsef_pkg::SPIN_FRAC_BITS);
         end
      end
      r.energy = sat32(-((mdl_coupling * esum) >>> fsef_pkg::COUPLING_FRAC));
      r.fx = sat32((mdl_coupling * f[0]) >>> fsef_pkg::COUPLING_FRAC);
      r.fy = sat32((mdl_coupling * f[1]) >>> fsef_pkg::COUPLING_FRAC);
      r.fz = sat32((mdl_coupling * f[2]) >>> fsef_pkg::COUPLING_FRAC);
      return r;
   endfunction

   function automatic void apply_item(logic [1:0] op, logic [111:0] d);
      int site, e;
      site = int'(d[11:0]);
      case (op)
         fsef_pkg::OP_SPIN: begin
            mdl_spin[site][0] = $signed(d[30:15]);
            mdl_spin[site][1] = $signed(d[46:31]);
            mdl_spin[site][2] = $signed(d[62:47]);
            if (!spin_written[site]) written_sites.push_back(site);
            spin_written[site] = 1'b1;
         end
         fsef_pkg::OP_CELL: begin
            e = site*fsef_pkg::MAX_CELLS + int'(d[14:12]);
            mdl_present[e] = d[63];
            for (int q = 0; q < 4; q++) mdl_idx[e][q] = d[64+12*q +: 12];
            if (d[63]) loaded_sites.push_back(site);
         end
         fsef_pkg::OP_QUERY: field_q.push_back(predict_site(site));
         default: ;
      endcase
   endfunction

   task automatic send_item(logic [1:0] op, logic [111:0] d);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= d;
      do @(posedge clock); while (!req_tready);
      apply_item(op, d);
      @(negedge clock);
   endtask

   task automatic idle_sender();
      req_tvalid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic send_spin(int site, int x, int y, int z);
      logic [111:0] d;
      d = '0;
      d[11:0] = 12'(site); d[30:15] = 16'(x); d[46:31] = 16'(y); d[62:47] = 16'(z);
      send_item(fsef_pkg::OP_SPIN, d);
   endtask

   task automatic send_cell(int site, int slot, bit pres, int a, int b, int c, int dd);
      logic [111:0] d;
      d = '0;
      d[11:0] = 12'(site); d[14:12] = 3'(slot); d[63] = pres;
      d[75:64] = 12'(a); d[87:76] = 12'(b); d[99:88] = 12'(c); d[111:100] = 12'(dd);
      send_item(fsef_pkg::OP_CELL, d);
   endtask

   task automatic send_query(int site);
      logic [111:0] d;
      d = 112'({$urandom, $urandom, $urandom, $urandom});
      d[11:0] = 12'(site);
      send_item(fsef_pkg::OP_QUERY, d);
   endtask

   // wait for all outstanding transactions, then let the block settle
   task automatic drain();
      idle_sender();
      while (field_q.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [15:0] val);
      drain();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         fsef_pkg::CSR_COUPLING: mdl_coupling = longint'($signed(val));
         fsef_pkg::CSR_CELLS:    mdl_cells = 32'(val[3:0]);
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   function automatic int rand_spin();
      return int'($urandom_range(32768)) - 16384;
   endfunction

   function automatic int pick_written();
      return written_sites[$urandom_range(written_sites.size()-1)];
   endfunction

   // long receiver hold-off, counted here
   initial begin
      forever begin
         @(hold_go);
         hold_on = 1'b1;
         repeat (HOLD_CYCLES) @(negedge clock);
         hold_on = 1'b0;
      end
   end

   // receiver: random stalls plus the long hold-off
   always @(negedge clock) begin
      if (hold_on) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      site_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (field_q.size() == 0) begin
            report("unexpected result", rsp_tdata[31:0], '0);
         end else begin
            want = field_q.pop_front();
            if (rsp_tdata[31:0] !== want.energy) report("energy", rsp_tdata[31:0], want.energy);
            if (rsp_tdata[63:32] !== want.fx) report("field_x", rsp_tdata[63:32], want.fx);
            if (rsp_tdata[95:64] !== want.fy) report("field_y", rsp_tdata[95:64], want.fy);
            if (rsp_tdata[127:96] !== want.fz) report("field_z", rsp_tdata[127:96], want.fz);
         end
      end
   end

   task automatic test_directed();
      send_spin(0, 16384, 0, 0);
      send_spin(4095, -16384, -16384, -16384);
      send_spin(2730, 16384, 16384, 16384);
      send_spin(1365, -16384, 16384, -1);
      send_cell(0, 0, 1'b1, 0, 4095, 2730, 1365);
      send_query(0);
      send_cell(4095, 7, 1'b1, 4095, 2730, 4095, 2730);
      send_cell(4095, 0, 1'b0, 4095, 4095, 4095, 4095);
      send_query(4095);
      send_item(OP_NONE, '1);
      write_csr(fsef_pkg::CSR_CELLS, 16'd8);
      send_query(4095);
      send_cell(4095, 3, 1'b1, 2730, 2730, 2730, 2730);
      send_query(4095);
      write_csr(fsef_pkg::CSR_COUPLING, 16'h8000);
      send_query(4095);
      send_query(0);
      write_csr(fsef_pkg::CSR_COUPLING, 16'h7fff);
      send_query(4095);
      write_csr(fsef_pkg::CSR_CELLS, 16'd0);
      send_query(4095);
      write_csr(fsef_pkg::CSR_CELLS, 16'd15);
      send_query(4095);
      write_csr(CSR_UNUSED, 16'hffff);
      send_query(0);
      send_query(1234);
   endtask

   task automatic random_items(int count);
      int r, site;
      for (int k = 0; k < count; k++) begin
         r = $urandom_range(99);
         if (r < 25) begin
            send_spin($urandom_range(4095), rand_spin(), rand_spin(), rand_spin());
         end else if (r < 55) begin
            site = ($urandom_range(3) == 0) ? $urandom_range(4095) : $urandom_range(15);
            if ($urandom_range(9) < 8)
               send_cell(site, $urandom_range(7), 1'b1, pick_written(), pick_written(),
                         pick_written(), pick_written());
            else
               send_cell(site, $urandom_range(7), 1'b0, $urandom_range(4095),
                         $urandom_range(4095), $urandom_range(4095), $urandom_range(4095));
         end else if (r < 97) begin
            if (loaded_sites.size() > 0 && $urandom_range(9) < 8)
               send_query(loaded_sites[$urandom_range(loaded_sites.size()-1)]);
            else
               send_query($urandom_range(4095));
         end else begin
            send_item(OP_NONE, 112'({$urandom, $urandom, $urandom, $urandom}));
         end
      end
   endtask

   task automatic test_random_phases();
      logic [15:0] coup [6] = '{16'h0100, 16'h7fff, 16'h8000, 16'hff00, 16'h0001, 16'h1234};
      for (int p = 0; p < 6; p++) begin
         write_csr(fsef_pkg::CSR_COUPLING, (p == 5) ? 16'($urandom) : coup[p]);
         write_csr(fsef_pkg::CSR_CELLS, (p % 2 == 0) ? 16'd8 : 16'($urandom_range(1, 8)));
         if (p == 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         random_items(250);
         send_idle_pct = 17;
         recv_idle_pct = 17;
      end
   endtask

   task automatic test_backpressure();
      write_csr(fsef_pkg::CSR_CELLS, 16'd8);
      -> hold_go;
      for (int k = 0; k < 25; k++)
         send_query(loaded_sites[$urandom_range(loaded_sites.size()-1)]);
      drain();
      random_items(150);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_phases();
      test_backpressure();
      drain();
      if (errors == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin
      #60000000;
      $display("Mismatches found");
      $finish;
   end

endmodule
